// ===== rtl/core/safl_pkg.sv =====
`timescale 1ns / 1ps
// shared types and codes for the symbol address floor lookup
// no dependencies

package safl_pkg;

	localparam int HW    = 16;
	localparam int AW    = 64;
	localparam int ANS_W = 3 + HW;

	localparam logic [31:0] OFFSET_LIMIT_RESET = 32'h0000_8000;

	localparam logic [1:0] ACT_LOAD_MOD = 2'd0;
	localparam logic [1:0] ACT_LOAD_MAP = 2'd1;
	localparam logic [1:0] ACT_LOOKUP   = 2'd2;
	localparam logic [1:0] ACT_CLEAR    = 2'd3;

	localparam logic [2:0] ST_FOUND   = 3'd0;
	localparam logic [2:0] ST_NONE    = 3'd1;
	localparam logic [2:0] ST_NULL    = 3'd2;
	localparam logic [2:0] ST_ONES    = 3'd3;
	localparam logic [2:0] ST_LOADED  = 3'd4;
	localparam logic [2:0] ST_FULL    = 3'd5;
	localparam logic [2:0] ST_CLEARED = 3'd6;

	typedef struct packed {
		logic [1:0]    action;
		logic [AW-1:0] address;
		logic [HW-1:0] symbol_handle;
	} in_item_t;

	typedef struct packed {
		logic [2:0]    status;
		logic [HW-1:0] result_handle;
		logic          cache_hit;
	} out_item_t;

	typedef enum logic [2:0] {
		K_LOAD_MOD,
		K_LOAD_MAP,
		K_LOOKUP,
		K_NULL,
		K_ONES,
		K_CLEAR
	} kind_t;

	typedef struct packed {
		kind_t         kind;
		logic [AW-1:0] address;
		logic [HW-1:0] handle;
	} job_t;

	typedef struct packed {
		logic [AW-1:0] addr;
		logic [HW-1:0] handle;
	} entry_t;

	typedef struct packed {
		logic          start;
		logic          load;
		logic          clear;
		logic [AW-1:0] key;
		entry_t        entry;
	} srch_cmd_t;

	typedef struct packed {
		logic   done;
		logic   match;
		logic   full;
		entry_t entry;
	} srch_res_t;

	typedef enum logic [1:0] {
		SR_IDLE,
		SR_FIRST,
		SR_LAST,
		SR_MID
	} srch_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CACHE,
		BK_SEARCH,
		BK_CHECK,
		BK_EMIT
	} back_state_t;

endpackage

// ===== rtl/core/symbol_address_floor_lookup.sv =====
`timescale 1ns / 1ps
// Symbol address floor lookup. Loads, clears, null and all-ones lookups and
// cache hits are answered without a search; a cache miss runs a floor binary
// search over both tables side by side, one table memory read a step. A
// two-entry queue after the input lets up to two beats be taken while a lookup
// runs, and the result register holds a finished beat while the next is worked
// on. Cache clears take effect at once.
// depends on safl_pkg, safl_front, safl_search, safl_back

module symbol_address_floor_lookup import safl_pkg::*; #(
	parameter int TABLE_DEPTH   = 4096,
	parameter int CACHE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  in_item_t    item,
	output logic        result_valid,
	input  logic        result_stall,
	output out_item_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] offset_limit_q;
	logic        job_valid;
	job_t        job;
	logic        pop;
	srch_cmd_t   mod_cmd, map_cmd;
	srch_res_t   mod_res, map_res;

	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? offset_limit_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			offset_limit_q <= OFFSET_LIMIT_RESET;
		else if (psel && penable && pwrite && paddr == 3'd0)
			offset_limit_q <= pwdata;
	end

	safl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.job_valid  (job_valid),
		.job        (job),
		.pop        (pop)
	);

	safl_search #(.TABLE_DEPTH(TABLE_DEPTH)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mod_cmd),
		.res    (mod_res)
	);

	safl_search #(.TABLE_DEPTH(TABLE_DEPTH)) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (map_cmd),
		.res    (map_res)
	);

	safl_back #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job),
		.pop          (pop),
		.offset_limit (offset_limit_q),
		.mod_cmd      (mod_cmd),
		.map_cmd      (map_cmd),
		.mod_res      (mod_res),
		.map_res      (map_res),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== rtl/core/safl_front.sv =====
`timescale 1ns / 1ps
// front part: accepts input beats, classifies them, holds them in a two-entry queue
// depends on safl_pkg

module safl_front import safl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  in_item_t item,
	output logic     job_valid,
	output job_t     job,
	input  logic     pop
);

	job_t       q_mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	job_t       job_in;

	always_comb begin
		job_in.address = item.address;
		job_in.handle  = item.symbol_handle;
		unique case (item.action)
			ACT_LOAD_MOD: job_in.kind = K_LOAD_MOD;
			ACT_LOAD_MAP: job_in.kind = K_LOAD_MAP;
			ACT_LOOKUP: begin
				if (item.address == '0)
					job_in.kind = K_NULL;
				else if (item.address == '1)
					job_in.kind = K_ONES;
				else
					job_in.kind = K_LOOKUP;
			end
			default: job_in.kind = K_CLEAR;
		endcase
	end

	assign item_stall = (cnt_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign job_valid  = (cnt_q != 2'd0);
	assign job        = q_mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_q] <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/safl_search.sv =====
`timescale 1ns / 1ps
// one symbol table with its floor binary search, one memory read a step
// depends on safl_pkg

module safl_search import safl_pkg::*; #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	input  srch_cmd_t cmd,
	output srch_res_t res
);

	localparam int IW  = $clog2(TABLE_DEPTH);
	localparam int CNW = $clog2(TABLE_DEPTH + 1);

	entry_t          mem [TABLE_DEPTH];
	entry_t          rd_data_q;
	logic [IW-1:0]   rd_addr;
	logic [CNW-1:0]  count_q;
	logic            full;
	logic [IW-1:0]   last;

	srch_state_t     state_q, state_d;
	logic [IW-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
	entry_t          lo_ent_q, lo_ent_d, hi_ent_q, hi_ent_d, pick_q, pick_d;
	logic            done_q, done_d, match_q, match_d;

	logic            ge, le;
	logic [IW-1:0]   nlo, nhi, span;
	entry_t          nloe, nhie;

	assign full = (count_q == CNW'(TABLE_DEPTH));
	assign last = IW'(count_q - CNW'(1));

	always_ff @(posedge clk) begin
		if (cmd.load && !full)
			mem[count_q[IW-1:0]] <= cmd.entry;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (cmd.clear)
			count_q <= '0;
		else if (cmd.load && !full)
			count_q <= count_q + CNW'(1);
	end

	always_comb begin
		ge   = cmd.key >= rd_data_q.addr;
		le   = cmd.key <= rd_data_q.addr;
		nlo  = ge ? mid_q : lo_q;
		nloe = ge ? rd_data_q : lo_ent_q;
		nhi  = le ? mid_q : hi_q;
		nhie = le ? rd_data_q : hi_ent_q;
		span = nhi - nlo;
	end

	always_comb begin
		state_d  = state_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		mid_d    = mid_q;
		lo_ent_d = lo_ent_q;
		hi_ent_d = hi_ent_q;
		pick_d   = pick_q;
		done_d   = done_q;
		match_d  = match_q;
		rd_addr  = mid_q;
		unique case (state_q)
			SR_IDLE: begin
				if (cmd.start) begin
					if (count_q == '0) begin
						done_d  = 1'b1;
						match_d = 1'b0;
					end else begin
						done_d  = 1'b0;
						rd_addr = '0;
						state_d = SR_FIRST;
					end
				end
			end
			SR_FIRST: begin
				lo_ent_d = rd_data_q;
				rd_addr  = last;
				state_d  = SR_LAST;
			end
			SR_LAST: begin
				if (cmd.key < lo_ent_q.addr) begin
					done_d  = 1'b1;
					match_d = 1'b0;
					state_d = SR_IDLE;
				end else if (ge) begin
					done_d  = 1'b1;
					match_d = 1'b1;
					pick_d  = rd_data_q;
					state_d = SR_IDLE;
				end else begin
					lo_d     = '0;
					hi_d     = last;
					hi_ent_d = rd_data_q;
					mid_d    = last >> 1;
					rd_addr  = last >> 1;
					state_d  = SR_MID;
				end
			end
			SR_MID: begin
				lo_d     = nlo;
				hi_d     = nhi;
				lo_ent_d = nloe;
				hi_ent_d = nhie;
				if (span <= IW'(1)) begin
					// equal to the upper bound picks the upper entry
					pick_d  = (cmd.key == nhie.addr) ? nhie : nloe;
					done_d  = 1'b1;
					match_d = 1'b1;
					state_d = SR_IDLE;
				end else begin
					mid_d   = nlo + (span >> 1);
					rd_addr = nlo + (span >> 1);
				end
			end
			default: state_d = SR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SR_IDLE;
			done_q  <= 1'b0;
			match_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			match_q <= match_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		mid_q    <= mid_d;
		lo_ent_q <= lo_ent_d;
		hi_ent_q <= hi_ent_d;
		pick_q   <= pick_d;
	end

	assign res.done  = done_q;
	assign res.match = match_q;
	assign res.full  = full;
	assign res.entry = pick_q;

endmodule

// ===== rtl/core/safl_back.sv =====
`timescale 1ns / 1ps
// back part: sequencer for loads, clears and lookups, answer cache, result register
// depends on safl_pkg; drives two safl_search tables

module safl_back import safl_pkg::*; #(
	parameter int CACHE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	input  job_t        job,
	output logic        pop,
	input  logic [31:0] offset_limit,
	output srch_cmd_t   mod_cmd,
	output srch_cmd_t   map_cmd,
	input  srch_res_t   mod_res,
	input  srch_res_t   map_res,
	output logic        result_valid,
	input  logic        result_stall,
	output out_item_t   result
);

	localparam int CW = $clog2(CACHE_ENTRIES);

	logic [AW-1:0]    cache_addr_mem [CACHE_ENTRIES];
	logic [ANS_W-1:0] cache_ans_mem  [CACHE_ENTRIES];
	logic [CACHE_ENTRIES-1:0] valid_q;
	logic [AW-1:0]    ca_rd_q;
	logic [ANS_W-1:0] an_rd_q;

	back_state_t      state_q, state_d;
	logic [AW-1:0]    a_q;
	logic [CW-1:0]    slot_q, slot;
	entry_t           chosen_q;
	logic             any_q;
	out_item_t        res_q, res_d;
	logic             res_load;
	out_item_t        result_q;
	logic             result_valid_q;
	logic             out_free;
	logic             hit;
	logic             use_mod;
	logic [AW-1:0]    diff;
	logic             over;
	logic             cache_wr;

	assign slot     = job.address[4 +: CW];
	assign out_free = !result_valid_q || !result_stall;
	assign hit      = valid_q[slot_q] && (ca_rd_q == a_q);
	assign use_mod  = (mod_res.match && map_res.match) ?
	                  (mod_res.entry.addr > map_res.entry.addr) : mod_res.match;
	assign diff     = a_q - chosen_q.addr;
	// an address below the chosen start counts as in range
	assign over     = (a_q >= chosen_q.addr) && (diff > {32'd0, offset_limit});

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		res_d    = res_q;
		res_load = 1'b0;
		cache_wr = 1'b0;
		mod_cmd  = '0;
		map_cmd  = '0;
		mod_cmd.key   = a_q;
		map_cmd.key   = a_q;
		mod_cmd.entry = '{addr: job.address, handle: job.handle};
		map_cmd.entry = '{addr: job.address, handle: job.handle};
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					pop      = 1'b1;
					res_d    = '0;
					res_load = 1'b1;
					state_d  = BK_EMIT;
					unique case (job.kind)
						K_LOAD_MOD: begin
							mod_cmd.load = 1'b1;
							res_d.status = mod_res.full ? ST_FULL : ST_LOADED;
						end
						K_LOAD_MAP: begin
							map_cmd.load = 1'b1;
							res_d.status = map_res.full ? ST_FULL : ST_LOADED;
						end
						K_NULL:  res_d.status = ST_NULL;
						K_ONES:  res_d.status = ST_ONES;
						K_CLEAR: begin
							mod_cmd.clear = 1'b1;
							map_cmd.clear = 1'b1;
							res_d.status  = ST_CLEARED;
						end
						K_LOOKUP: begin
							res_load = 1'b0;
							state_d  = BK_CACHE;
						end
						default: state_d = BK_EMIT;
					endcase
				end
			end
			BK_CACHE: begin
				if (hit) begin
					res_d.status        = an_rd_q[ANS_W-1 -: 3];
					res_d.result_handle = an_rd_q[HW-1:0];
					res_d.cache_hit     = 1'b1;
					res_load            = 1'b1;
					state_d             = BK_EMIT;
				end else begin
					mod_cmd.start = 1'b1;
					map_cmd.start = 1'b1;
					state_d       = BK_SEARCH;
				end
			end
			BK_SEARCH: begin
				if (mod_res.done && map_res.done)
					state_d = BK_CHECK;
			end
			BK_CHECK: begin
				res_d.cache_hit = 1'b0;
				if (any_q && !over) begin
					res_d.status        = ST_FOUND;
					res_d.result_handle = chosen_q.handle;
				end else begin
					res_d.status        = ST_NONE;
					res_d.result_handle = '0;
				end
				res_load = 1'b1;
				cache_wr = 1'b1;
				state_d  = BK_EMIT;
			end
			BK_EMIT: begin
				if (out_free)
					state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cache_wr) begin
			cache_addr_mem[slot_q] <= a_q;
			cache_ans_mem[slot_q]  <= {res_d.status, res_d.result_handle};
		end
		ca_rd_q <= cache_addr_mem[slot];
		an_rd_q <= cache_ans_mem[slot];
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE) begin
			a_q    <= job.address;
			slot_q <= slot;
		end
		if (state_q == BK_SEARCH) begin
			chosen_q <= use_mod ? mod_res.entry : map_res.entry;
			any_q    <= mod_res.match || map_res.match;
		end
		if (res_load)
			res_q <= res_d;
		if (state_q == BK_EMIT && out_free)
			result_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= BK_IDLE;
			valid_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_IDLE && job_valid && job.kind == K_CLEAR)
				valid_q <= '0;
			else if (cache_wr)
				valid_q[slot_q] <= 1'b1;
			if (state_q == BK_EMIT && out_free)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== bench/tb_symbol_address_floor_lookup.sv =====
`timescale 1ns / 1ps
// self-checking bench for symbol_address_floor_lookup: random and directed
// loads, lookups and clears checked against an in-bench model; needs safl_pkg

module tb_symbol_address_floor_lookup;
	import safl_pkg::*;

	localparam int DEPTH = 4096;
	localparam int SLOTS = 256;
	localparam int MAX_CYCLES = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	in_item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_item_t result;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	symbol_address_floor_lookup DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// lookup state mirror
	logic [31:0] offset_limit;
	logic [63:0] mod_addr [DEPTH];
	logic [15:0] mod_hdl [DEPTH];
	int mod_cnt;
	logic [63:0] map_addr [DEPTH];
	logic [15:0] map_hdl [DEPTH];
	int map_cnt;
	logic [63:0] memo_addr [SLOTS];
	logic [18:0] memo_ans [SLOTS];

	in_item_t pending_beats [$];
	out_item_t expected_results [$];
	int errors = 0, cycles = 0, hits_seen = 0, found_seen = 0, full_seen = 0;
	bit quiet = 1'b0, hold_long = 1'b0;

	function automatic bit floor_pos(input bit is_map, input int cnt,
			input logic [63:0] a, output int pos);
		int lo, hi, mid;
		logic [63:0] t [DEPTH];
		if (is_map) t = map_addr;
		else t = mod_addr;
		if (cnt == 0 || a < t[0]) return 0;
		if (a >= t[cnt-1]) begin
			pos = cnt - 1;
			return 1;
		end
		lo = 0;
		hi = cnt - 1;
		forever begin
			mid = lo + (hi - lo) / 2;
			if (a >= t[mid]) lo = mid;
			if (a <= t[mid]) hi = mid;
			if (hi - lo <= 1) break;
		end
		pos = (a == t[hi]) ? hi : lo;
		return 1;
	endfunction

	function automatic out_item_t resolve(input in_item_t b);
		out_item_t r;
		int slot, mp, pp;
		bit mok, pok, um;
		logic [63:0] st;
		r = '0;
		case (b.action)
			ACT_LOAD_MOD: begin
				if (mod_cnt >= DEPTH) r.status = ST_FULL;
				else begin
					mod_addr[mod_cnt] = b.address;
					mod_hdl[mod_cnt] = b.symbol_handle;
					mod_cnt++;
					r.status = ST_LOADED;
				end
			end
			ACT_LOAD_MAP: begin
				if (map_cnt >= DEPTH) r.status = ST_FULL;
				else begin
					map_addr[map_cnt] = b.address;
					map_hdl[map_cnt] = b.symbol_handle;
					map_cnt++;
					r.status = ST_LOADED;
				end
			end
			ACT_CLEAR: begin
				mod_cnt = 0;
				map_cnt = 0;
				foreach (memo_addr[i]) begin
					memo_addr[i] = '0;
					memo_ans[i] = '0;
				end
				r.status = ST_CLEARED;
			end
			default: begin
				slot = int'(b.address[11:4]);
				if (b.address == '0) r.status = ST_NULL;
				else if (&b.address) r.status = ST_ONES;
				else if (memo_addr[slot] == b.address) begin
					r.status = memo_ans[slot][18:16];
					r.result_handle = memo_ans[slot][15:0];
					r.cache_hit = 1'b1;
				end else begin
					mok = floor_pos(1'b0, mod_cnt, b.address, mp);
					pok = floor_pos(1'b1, map_cnt, b.address, pp);
					um = (mok && pok) ? (mod_addr[mp] > map_addr[pp]) : mok;
					r.status = ST_NONE;
					if (mok || pok) begin
						st = um ? mod_addr[mp] : map_addr[pp];
						r.result_handle = um ? mod_hdl[mp] : map_hdl[pp];
						if (b.address >= st && (b.address - st) > {32'd0, offset_limit})
							r.result_handle = '0;
						else r.status = ST_FOUND;
					end
					memo_addr[slot] = b.address;
					memo_ans[slot] = {r.status, r.result_handle};
				end
			end
		endcase
		return r;
	endfunction

	// driver
	int gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				expected_results.push_back(resolve(item));
				void'(pending_beats.pop_front());
			end
			if (item_valid && item_stall) begin
				// hold the stalled beat
			end else if (gap > 0) begin
				gap <= gap - 1;
				item_valid <= 1'b0;
			end else if (pending_beats.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
				gap <= $urandom_range(0, 3);
				item_valid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				item <= pending_beats[0];
				item_valid <= 1'b1;
			end else item_valid <= 1'b0;
		end
	end

	// monitor
	int stall_burst = 0, hold_count = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected beat %p", result);
				end else begin
					out_item_t e;
					e = expected_results.pop_front();
					if (result.status == ST_FOUND) found_seen++;
					if (result.status == ST_FULL) full_seen++;
					if (result.cache_hit) hits_seen++;
					if (result.status !== e.status || result.result_handle !== e.result_handle
							|| result.cache_hit !== e.cache_hit) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %p got %p", e, result);
					end
				end
			end
			if (hold_long && hold_count < 200) begin
				hold_count <= hold_count + 1;
				result_stall <= 1'b1;
			end else if (stall_burst > 0) begin
				stall_burst <= stall_burst - 1;
				result_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_burst <= $urandom_range(0, 3);
				result_stall <= 1'b1;
			end else result_stall <= 1'b0;
		end
		if (cycles > MAX_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic push(input logic [1:0] act, input logic [63:0] a, input logic [15:0] h);
		in_item_t b;
		b.action = act;
		b.address = a;
		b.symbol_handle = h;
		pending_beats.push_back(b);
	endtask

	task automatic drain();
		while (pending_beats.size() > 0 || item_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_offset(input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		offset_limit = v;
	endtask

	// a sorted set of symbols spread over both tables, then lookups around them
	task automatic symbol_set(input int n, input logic [63:0] base);
		logic [63:0] a, pts [$];
		a = base;
		for (int i = 0; i < n; i++) begin
			a += 64'($urandom_range(1, 'h20000));
			pts.push_back(a);
			push($urandom_range(0, 1) ? ACT_LOAD_MAP : ACT_LOAD_MOD, a, 16'($urandom));
		end
		for (int i = 0; i < 3 * n; i++) begin
			case ($urandom_range(0, 4))
				0: a = pts[$urandom_range(0, n - 1)];
				1: a = pts[$urandom_range(0, n - 1)] + 64'($urandom_range(0, 'h9000));
				2: a = base + 64'($urandom_range(0, 'h200000));
				3: a = pts[$urandom_range(0, n - 1)] - 64'd1;
				default: a = {$urandom, $urandom};
			endcase
			push(ACT_LOOKUP, a, 16'($urandom));
			if ($urandom_range(0, 5) == 0) push(ACT_LOOKUP, a, 16'($urandom));
		end
	endtask

	logic [31:0] settings [4] = '{32'd0, 32'hffff_ffff, 32'h10, 32'h0000_8000};

	initial begin
		offset_limit = OFFSET_LIMIT_RESET;
		mod_cnt = 0;
		map_cnt = 0;
		foreach (memo_addr[i]) begin
			memo_addr[i] = '0;
			memo_ans[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty tables, null, all ones, both tables, tie, unsorted
		push(ACT_LOOKUP, 64'h1234, 16'hffff);
		push(ACT_LOOKUP, 64'h0, 16'd0);
		push(ACT_LOOKUP, '1, 16'd0);
		push(ACT_LOAD_MOD, 64'h1000, 16'hffff);
		push(ACT_LOAD_MAP, 64'h1000, 16'h0001);
		push(ACT_LOAD_MOD, 64'h8000_0000_0000_0000, 16'haaaa);
		push(ACT_LOAD_MAP, 64'hffff_ffff_ffff_fffe, 16'h5555);
		push(ACT_LOAD_MOD, 64'h10, 16'h7777);
		push(ACT_LOOKUP, 64'h1000, 16'd0);
		push(ACT_LOOKUP, 64'h1000, 16'd0);
		push(ACT_LOOKUP, 64'h9001, 16'd0);
		push(ACT_LOOKUP, 64'h8000_0000_0000_7fff, 16'd0);
		push(ACT_LOOKUP, 64'hffff_ffff_ffff_fffe, 16'd0);
		push(ACT_LOOKUP, 64'h8, 16'd0);
		push(ACT_LOOKUP, 64'h20, 16'd0);
		push(ACT_CLEAR, '1, '1);
		push(ACT_LOOKUP, 64'h1000, 16'd0);
		drain();
		// fill one table past its depth
		for (int i = 0; i < DEPTH + 2; i++)
			push(ACT_LOAD_MAP, 64'(i) * 64'h40 + 64'h100, 16'(i));
		for (int i = 0; i < 30; i++)
			push(ACT_LOOKUP, {1'($urandom_range(0, 1)), 31'd0, $urandom}, 16'd0);
		push(ACT_LOAD_MOD, 64'h200, 16'hbeef);
		push(ACT_LOOKUP, 64'h200, 16'd0);
		push(ACT_CLEAR, 64'd0, 16'd0);
		drain();
		foreach (settings[s]) begin
			write_offset(settings[s]);
			for (int r = 0; r < 4; r++) begin
				symbol_set($urandom_range(4, 40),
					{2'($urandom_range(0, 3)), 30'd0, $urandom});
				if (s == 1 && r == 1) hold_long = 1'b1;
				for (int i = 0; i < 8; i++)
					push($urandom_range(0, 3) == 3 ? ACT_LOOKUP : 2'($urandom),
						{$urandom, $urandom}, 16'($urandom));
				push(ACT_CLEAR, {$urandom, $urandom}, 16'($urandom));
				if (s == 3 && r == 2) quiet = 1'b1;
				while (pending_beats.size() > 0) @(posedge clk);
			end
			drain();
		end
		drain();
		$display("covered loads, lookups, clears, a full table, %0d cache hits", hits_seen);
		$display("%0d found answers, %0d table-full reports, 4 offset settings",
			found_seen, full_seen);
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
